@@ design/rccs_pkg.sv @@
// Package: shared types, register indexes, reset values and color masks for the sequencer.
package rccs_pkg;

    // Widths fixed by the field definitions
    localparam int DUTY_W  = 13;
    localparam int CNT_W   = 5;
    localparam int SEQ_W   = 48;
    localparam int CODE_W  = 3;
    localparam int SHOW_W  = 4;
    localparam int REG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_COUNT    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_SEQUENCE = 2'd2;

    // Register reset values
    localparam logic [DUTY_W-1:0] BRIGHTNESS_RST     = 13'd2000;
    localparam logic [CNT_W-1:0]  COLOR_COUNT_RST    = 5'd2;
    localparam logic [SEQ_W-1:0]  COLOR_SEQUENCE_RST = 48'd1754760;

    // Color codes
    localparam logic [CODE_W-1:0] COLOR_RED    = 3'd0;
    localparam logic [CODE_W-1:0] COLOR_GREEN  = 3'd1;
    localparam logic [CODE_W-1:0] COLOR_BLUE   = 3'd2;
    localparam logic [CODE_W-1:0] COLOR_YELLOW = 3'd3;
    localparam logic [CODE_W-1:0] COLOR_PURPLE = 3'd4;
    localparam logic [CODE_W-1:0] COLOR_CYAN   = 3'd5;
    localparam logic [CODE_W-1:0] COLOR_WHITE  = 3'd6;
    localparam logic [CODE_W-1:0] COLOR_NONE   = 3'd7;

    // Input beat payload
    typedef struct packed {
        logic tick;
    } tick_t;

    // Result beat payload
    typedef struct packed {
        logic [DUTY_W-1:0] red_out;
        logic [DUTY_W-1:0] green_out;
        logic [DUTY_W-1:0] blue_out;
        logic [SHOW_W-1:0] showing_index;
        logic              in_fade;
    } result_t;

    // Configuration write beat payload
    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        logic [SEQ_W-1:0]     value;
    } cfg_t;

    // Channel mask of a color code: bit 0 red, bit 1 green, bit 2 blue
    function automatic logic [2:0] chan_mask(input logic [CODE_W-1:0] code);
        logic [2:0] m;
        unique case (code)
            COLOR_RED:    m = 3'b001;
            COLOR_GREEN:  m = 3'b010;
            COLOR_BLUE:   m = 3'b100;
            COLOR_YELLOW: m = 3'b011;
            COLOR_PURPLE: m = 3'b101;
            COLOR_CYAN:   m = 3'b110;
            COLOR_WHITE:  m = 3'b111;
            COLOR_NONE:   m = 3'b000;
            default:      m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

@@ design/rccs_stream_if.sv @@
// Interface: valid/ready channel carrying one payload beat of a given type.
interface rccs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/rccs_in_stage.sv @@
// Input register stage: captures one tick beat and holds it until the step stage takes it.
module rccs_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    rccs_stream_if.sink         up,
    rccs_stream_if.source       down
);

    logic           valid_reg;
    logic           valid_next;
    rccs_pkg::tick_t data_reg;

    // Free when empty or when the held beat leaves this cycle
    assign up.ready = !valid_reg || down.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (up.ready)
        begin
            valid_next = up.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (up.ready && up.valid)
        begin
            data_reg <= up.data;
        end
    end

    assign down.valid = valid_reg;
    assign down.data  = data_reg;

endmodule

@@ design/rccs_step.sv @@
// Step stage: configuration registers, sequencer state, one-tick update and result register.
module rccs_step #(
    parameter int MAX_COLORS = 16,
    parameter int PWM_PERIOD = 5000
) (
    input  logic                clk,
    input  logic                rst_n,
    rccs_stream_if.sink         cfg,
    rccs_stream_if.sink         up,
    rccs_stream_if.source       result
);

    localparam int DW = rccs_pkg::DUTY_W;
    localparam int IW = rccs_pkg::CNT_W;
    localparam logic [IW-1:0] MAX_CNT  = IW'(MAX_COLORS);
    localparam logic [DW-1:0] FULL_MAX = DW'(PWM_PERIOD);

    // Configuration registers
    logic [DW-1:0]             brightness_reg;
    logic [IW-1:0]             color_count_reg;
    logic [rccs_pkg::SEQ_W-1:0] color_sequence_reg;

    // Sequencer state
    logic [IW-1:0]              list_index_reg,     list_index_next;
    logic [rccs_pkg::CODE_W-1:0] previous_color_reg, previous_color_next;
    logic                       fade_phase_reg,     fade_phase_next;
    logic [DW-1:0]              step_count_reg,     step_count_next;
    logic [DW-1:0]              red_level_reg,      red_level_next;
    logic [DW-1:0]              green_level_reg,    green_level_next;
    logic [DW-1:0]              blue_level_reg,     blue_level_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    rccs_pkg::result_t out_data_reg;

    logic       take;
    logic [IW-1:0] count;
    logic [DW-1:0] full;
    logic [DW-1:0] hold;
    logic [IW-1:0] li;
    logic [IW-1:0] li_inc;
    logic [rccs_pkg::CODE_W-1:0] code;
    logic [2:0]    old_mask;
    logic [2:0]    new_mask;
    logic [2:0]    fade_out_mask;
    logic [2:0]    fade_in_mask;
    logic [DW-1:0] st;
    logic [DW-1:0] duty_down;
    logic [DW:0]   hold_cnt;
    logic          do_hold;
    logic [DW-1:0] levels [3];
    logic [DW-1:0] levels_next [3];

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg     <= rccs_pkg::BRIGHTNESS_RST;
            color_count_reg    <= rccs_pkg::COLOR_COUNT_RST;
            color_sequence_reg <= rccs_pkg::COLOR_SEQUENCE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                rccs_pkg::REG_BRIGHTNESS:
                    brightness_reg <= cfg.data.value[DW-1:0];
                rccs_pkg::REG_COLOR_COUNT:
                    color_count_reg <= cfg.data.value[IW-1:0];
                rccs_pkg::REG_COLOR_SEQUENCE:
                    color_sequence_reg <= cfg.data.value;
                default:
                    ;
            endcase
        end
    end

    // Handshake: a beat is processed when the result register can take it
    assign up.ready = !out_valid_reg || result.ready;
    assign take     = up.valid && up.ready;

    // Clamped count, full duty and hold length
    assign count = (color_count_reg > MAX_CNT) ? MAX_CNT : color_count_reg;
    assign full  = (brightness_reg > FULL_MAX) ? FULL_MAX : brightness_reg;
    assign hold  = (full[DW-1:1] == '0) ? DW'(1) : (full >> 1);

    // Current list entry, wrapping a stale position
    assign li     = (list_index_reg >= count) ? '0 : list_index_reg;
    assign li_inc = li + IW'(1);
    assign code   = rccs_pkg::CODE_W'(color_sequence_reg >> ({2'b00, li} * 7'd3));

    // Fade channel selection and duties
    assign old_mask      = rccs_pkg::chan_mask(previous_color_reg);
    assign new_mask      = rccs_pkg::chan_mask(code);
    assign fade_out_mask = old_mask & ~new_mask;
    assign fade_in_mask  = new_mask & ~old_mask;
    assign st            = (step_count_reg > full) ? full : step_count_reg;
    assign duty_down     = full - st;

    assign levels[0] = red_level_reg;
    assign levels[1] = green_level_reg;
    assign levels[2] = blue_level_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            levels_next[c] = levels[c];
            if (fade_out_mask[c])
            begin
                levels_next[c] = duty_down;
            end
            else if (fade_in_mask[c])
            begin
                levels_next[c] = st;
            end
        end
    end

    // One tick of the sequencer
    always_comb
    begin
        list_index_next     = list_index_reg;
        previous_color_next = previous_color_reg;
        fade_phase_next     = fade_phase_reg;
        step_count_next     = step_count_reg;
        red_level_next      = red_level_reg;
        green_level_next    = green_level_reg;
        blue_level_next     = blue_level_reg;
        do_hold             = 1'b0;
        hold_cnt            = '0;

        if (up.data.tick && (count != '0))
        begin
            list_index_next = li;
            if (fade_phase_reg)
            begin
                // Same color as before: skip the fade, spend the tick holding
                if ((step_count_reg == '0) && (code == previous_color_reg))
                begin
                    fade_phase_next = 1'b0;
                    do_hold         = 1'b1;
                end
                else
                begin
                    red_level_next   = levels_next[0];
                    green_level_next = levels_next[1];
                    blue_level_next  = levels_next[2];
                    if (st >= full)
                    begin
                        previous_color_next = code;
                        fade_phase_next     = 1'b0;
                        step_count_next     = '0;
                    end
                    else
                    begin
                        step_count_next = st + DW'(1);
                    end
                end
            end
            else
            begin
                do_hold = 1'b1;
            end

            if (do_hold)
            begin
                hold_cnt = {1'b0, step_count_reg} + (DW+1)'(1);
                if (hold_cnt >= {1'b0, hold})
                begin
                    list_index_next = (li_inc >= count) ? '0 : li_inc;
                    fade_phase_next = 1'b1;
                    step_count_next = '0;
                end
                else
                begin
                    step_count_next = hold_cnt[DW-1:0];
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_index_reg     <= '0;
            previous_color_reg <= rccs_pkg::COLOR_NONE;
            fade_phase_reg     <= 1'b1;
            step_count_reg     <= '0;
            red_level_reg      <= '0;
            green_level_reg    <= '0;
            blue_level_reg     <= '0;
        end
        else if (take)
        begin
            list_index_reg     <= list_index_next;
            previous_color_reg <= previous_color_next;
            fade_phase_reg     <= fade_phase_next;
            step_count_reg     <= step_count_next;
            red_level_reg      <= red_level_next;
            green_level_reg    <= green_level_next;
            blue_level_reg     <= blue_level_next;
        end
    end

    // Result valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (up.ready)
        begin
            out_valid_next = up.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload reports the state after the tick
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg.red_out       <= red_level_next;
            out_data_reg.green_out     <= green_level_next;
            out_data_reg.blue_out      <= blue_level_next;
            out_data_reg.showing_index <= rccs_pkg::SHOW_W'(list_index_next);
            out_data_reg.in_fade       <= fade_phase_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

@@ design/rgb_color_crossfade_sequencer.sv @@
// Top level of the RGB color crossfade sequencer: input stage and step stage.
//
//   channel    dir  payload                                          beat
//   tick_ch    in   tick                                             one millisecond step
//   result_ch  out  red_out green_out blue_out showing_index in_fade one per tick beat
//   cfg_ch     in   index value                                      one register write
//
// Each tick beat is registered in the input stage, then the update logic writes the
// sequencer state and the result register from it; while result_ch does not
// stall, one beat per cycle is sustained.
// Reset clears the state to the start of a fade from no color and loads the
// register defaults. A stall on result_ch holds the result register and then
// the input register; configuration writes are always taken.
module rgb_color_crossfade_sequencer #(
    parameter int MAX_COLORS = 16,
    parameter int PWM_PERIOD = 5000
) (
    input  logic          clk,
    input  logic          rst_n,
    rccs_stream_if.sink   tick_ch,
    rccs_stream_if.source result_ch,
    rccs_stream_if.sink   cfg_ch
);

    // Link between the input register and the step stage
    rccs_stream_if #(.T(rccs_pkg::tick_t)) stage_ch ();

    rccs_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (tick_ch),
        .down  (stage_ch)
    );

    rccs_step #(
        .MAX_COLORS (MAX_COLORS),
        .PWM_PERIOD (PWM_PERIOD)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .up     (stage_ch),
        .result (result_ch)
    );

endmodule
